/* design/utf8_to_ucs2_decoder_macros.svh */
// assertion macros for the utf-8 to ucs-2 decoder
`ifndef UTF8_TO_UCS2_DECODER_MACROS_SVH
`define UTF8_TO_UCS2_DECODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define U8U2_ASSERT_NOW(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define U8U2_ASSERT_NEXT(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

/* design/u8u2_pkg.sv */
// shared types and constants for the utf-8 to ucs-2 decoder
package u8u2_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned UnitW   = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 16;
  localparam int unsigned OutW    = UnitW + StatusW + CountW;
  localparam int unsigned OutDataW = ((OutW + 7) / 8) * 8;

  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [UnitW-1:0]   unit_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [CountW-1:0]  count_t;

  // status codes; the bad-sequence codes equal the sequence length
  localparam status_t StOk      = 3'd0;
  localparam status_t StFull    = 3'd1;
  localparam status_t StBad2    = 3'd2;
  localparam status_t StBad3    = 3'd3;
  localparam status_t StBad4    = 3'd4;
  localparam status_t StBadLead = 3'd5;

  localparam count_t MaxUnitsReset = 16'd512;

endpackage

/* design/utf8_to_ucs2_decoder.sv */
// utf-8 to ucs-2 decoder top level
//
// Takes one utf-8 byte per transaction on the slave side; tlast marks the end
// item that closes a string (its byte is ignored). Every completed 1- to
// 4-byte sequence gives one master transaction with tuser high and the low 16
// bits of the code point. The end item gives one transaction with tlast high
// carrying the status (0 ok, 1 buffer full, 2/3/4 bad 2/3/4-byte sequence,
// 5 bad lead byte) and the number of units emitted, then the string state
// clears. After the first error no units are emitted until the end item.
// At most cfg_data-1 units are emitted per string, none when cfg_data is 0
// (cfg_data resets to 512).
// Throughput is one byte per clock while the master side does not stall: the
// byte lands in an input register, the decode and state update is one short
// combinational step, and the result goes to an output register, from which it
// is offered on the master side. A stall on the master side holds both registers;
// the input register keeps accepting while it is free.
// cfg_data may be written only while no transaction is in flight.
module utf8_to_ucs2_decoder (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  u8u2_pkg::byte_t          s_axis_tdata,   // in_byte
  input  logic                     s_axis_tlast,   // end_mark
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [u8u2_pkg::OutDataW-1:0] m_axis_tdata, // code_unit, status, unit_count, zero pad
  output logic                     m_axis_tuser,   // unit_valid
  output logic                     m_axis_tlast,   // done_res
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  u8u2_pkg::count_t         cfg_data        // max_units
);
  import u8u2_pkg::*;

  // configuration
  count_t max_units;

  // input register
  logic  in_valid;
  byte_t in_byte;
  logic  in_last;

  // string state
  logic [1:0] bytes_pending, bytes_pending_next;
  status_t    seq_length, seq_length_next;
  // low 10 bits are all that a following continuation byte needs
  logic [9:0] partial_point, partial_point_next;
  count_t     units_written, units_written_next;
  status_t    error_code, error_code_next;

  // output register
  logic    out_valid;
  unit_t   out_unit;
  status_t out_status;
  count_t  out_count;
  logic    out_unit_valid;
  logic    out_done;

  // decode results
  logic    res_valid;
  unit_t   res_unit;
  status_t res_status;
  count_t  res_count;
  logic    res_unit_valid;
  logic    res_done;

  logic    advance;
  logic    proc;
  logic    cap_full;
  unit_t   shifted_point;
  count_t  count_inc;

  // assertion terms
  logic    str_idle;
  logic    err_drop;
  logic    out_is_unit;

  assign cfg_ready = 1'b1;

  // the whole pipe moves unless a result is stuck at the output
  assign advance       = !out_valid || m_axis_tready;
  assign proc          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  assign count_inc     = units_written + 16'd1;
  // units_written+1 >= max_units, done at 17 bits so the wrap is not lost
  assign cap_full      = ({1'b0, units_written} + 17'd1) >= {1'b0, max_units};
  // only the low 16 bits of the code point are ever needed
  assign shifted_point = {partial_point, in_byte[5:0]};

  always_comb begin
    bytes_pending_next = bytes_pending;
    seq_length_next    = seq_length;
    partial_point_next = partial_point;
    units_written_next = units_written;
    error_code_next    = error_code;
    res_valid          = 1'b0;
    res_unit           = '0;
    res_status         = StOk;
    res_count          = units_written;
    res_unit_valid     = 1'b0;
    res_done           = 1'b0;
    if (proc) begin
      if (in_last) begin
        // end item: report, then clear for the next string
        res_valid = 1'b1;
        res_done  = 1'b1;
        if (error_code == StOk && bytes_pending != 2'd0) begin
          res_status = seq_length;
        end else begin
          res_status = error_code;
        end
        bytes_pending_next = '0;
        seq_length_next    = '0;
        partial_point_next = '0;
        units_written_next = '0;
        error_code_next    = StOk;
      end else if (error_code != StOk) begin
        // swallow bytes after an error
      end else if (bytes_pending != 2'd0) begin
        if (in_byte[7:6] != 2'b10) begin
          error_code_next    = seq_length;
          bytes_pending_next = '0;
        end else begin
          partial_point_next = shifted_point[9:0];
          bytes_pending_next = bytes_pending - 2'd1;
          if (bytes_pending == 2'd1) begin
            seq_length_next    = '0;
            units_written_next = count_inc;
            res_valid          = 1'b1;
            res_unit_valid     = 1'b1;
            res_unit           = shifted_point;
            res_count          = count_inc;
          end
        end
      end else if (cap_full) begin
        error_code_next = StFull;
      end else begin
        case (in_byte) inside
          8'b0???????: begin
            units_written_next = count_inc;
            res_valid          = 1'b1;
            res_unit_valid     = 1'b1;
            res_unit           = {8'd0, in_byte};
            res_count          = count_inc;
          end
          8'b110?????: begin
            partial_point_next = {5'd0, in_byte[4:0]};
            seq_length_next    = StBad2;
            bytes_pending_next = 2'd1;
          end
          8'b1110????: begin
            partial_point_next = {6'd0, in_byte[3:0]};
            seq_length_next    = StBad3;
            bytes_pending_next = 2'd2;
          end
          8'b11110???: begin
            partial_point_next = {7'd0, in_byte[2:0]};
            seq_length_next    = StBad4;
            bytes_pending_next = 2'd3;
          end
          default: begin
            // continuation byte or 0xf8..0xff in lead position
            error_code_next = StBadLead;
          end
        endcase
      end
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_units <= MaxUnitsReset;
    end else if (cfg_valid && cfg_ready) begin
      max_units <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // string state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= '0;
      seq_length    <= '0;
      partial_point <= '0;
      units_written <= '0;
      error_code    <= StOk;
    end else begin
      bytes_pending <= bytes_pending_next;
      seq_length    <= seq_length_next;
      partial_point <= partial_point_next;
      units_written <= units_written_next;
      error_code    <= error_code_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_unit       <= res_unit;
      out_status     <= res_status;
      out_count      <= res_count;
      out_unit_valid <= res_unit_valid;
      out_done       <= res_done;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OutDataW - OutW){1'b0}}, out_count, out_status, out_unit};
  assign m_axis_tuser  = out_unit_valid;
  assign m_axis_tlast  = out_done;

  assign str_idle    = units_written == '0 && error_code == StOk && bytes_pending == 2'd0;
  assign err_drop    = proc && !in_last && error_code != StOk;
  assign out_is_unit = out_valid && out_unit_valid;

`include "utf8_to_ucs2_decoder_macros.svh"

  // an end item always leaves a cleared string state behind
  `U8U2_ASSERT_NEXT(a_end_clears, clk, rst, proc && in_last, str_idle, "state not cleared")

  // once an error is latched, ordinary bytes produce no result
  `U8U2_ASSERT_NEXT(a_err_silent, clk, rst, err_drop, !out_valid, "result after an error")

  // a result is either a unit or an end report, never both
  `U8U2_ASSERT_NOW(a_kind_excl, clk, rst, out_valid, out_unit_valid != out_done, "bad result kind")

  // emitted units stay below the buffer size
  `U8U2_ASSERT_NOW(a_cap_kept, clk, rst, out_is_unit, out_count < max_units, "buffer size exceeded")

endmodule
